### rtl/logistic_map_bifurcation_point_gen_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the logistic map bifurcation point generator.
// ---------------------------------------------------------------------------
`ifndef LOGISTIC_MAP_BIFURCATION_POINT_GEN_ASSERT_SVH
`define LOGISTIC_MAP_BIFURCATION_POINT_GEN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMBP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmbp assertion failed");

`endif

### rtl/lmbp_pkg.sv
// ---------------------------------------------------------------------------
// lmbp_pkg
// Shared widths, constants, codes and types of the bifurcation point block.
// ---------------------------------------------------------------------------
package lmbp_pkg;

   // Field and register widths.
   localparam int COL_W      = 14;
   localparam int ROW_W      = 12;
   localparam int X_W        = 32;
   localparam int RATE_W     = 32;
   localparam int RATE_FRAC  = 29;
   localparam int CNT_W      = 12;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 64;

   // Growth rate ceiling of 4.0 in Q3.29 and the tallest usable image.
   localparam logic [RATE_W-1:0]   RATE_FOUR  = 32'h8000_0000;
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_RATE_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_INC   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ITER_TOTAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_X_START    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT     = 3'd5;

   // Register reset values.
   localparam logic [RATE_W-1:0]   RST_RATE_MIN   = 32'd1342177280;
   localparam logic [RATE_W-1:0]   RST_RATE_INC   = 32'd67114;
   localparam logic [CNT_W-1:0]    RST_ITER_TOTAL = 12'd2000;
   localparam logic [CNT_W-1:0]    RST_KEEP_COUNT = 12'd400;
   localparam logic [X_W-1:0]      RST_X_START    = 32'h8000_0000;
   localparam logic [HEIGHT_W-1:0] RST_HEIGHT     = 13'd4000;

   // Operand selection of the shared multiplier.
   localparam logic [1:0] MUL_RATE  = 2'd0;
   localparam logic [1:0] MUL_XX    = 2'd1;
   localparam logic [1:0] MUL_GROW  = 2'd2;
   localparam logic [1:0] MUL_ROW   = 2'd3;

   typedef struct packed {
      logic [RATE_W-1:0]   rate_min;
      logic [RATE_W-1:0]   rate_increment;
      logic [CNT_W-1:0]    iteration_total;
      logic [CNT_W-1:0]    keep_count;
      logic [X_W-1:0]      x_start;
      logic [HEIGHT_W-1:0] image_height;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take_item;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       load_column;
      logic       update_x;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exhausted;
      logic total_zero;
      logic keep_point;
      logic out_free;
   } status_type;

endpackage

### rtl/lmbp_csr.sv
// ---------------------------------------------------------------------------
// lmbp_csr
// Configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
module lmbp_csr
   import lmbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_RATE_MIN:   cfg_in.rate_min        = csr_wdata[RATE_W-1:0];
            REG_RATE_INC:   cfg_in.rate_increment  = csr_wdata[RATE_W-1:0];
            REG_ITER_TOTAL: cfg_in.iteration_total = csr_wdata[CNT_W-1:0];
            REG_KEEP_COUNT: cfg_in.keep_count      = csr_wdata[CNT_W-1:0];
            REG_X_START:    cfg_in.x_start         = csr_wdata[X_W-1:0];
            REG_HEIGHT:     cfg_in.image_height    = csr_wdata[HEIGHT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_min        <= RST_RATE_MIN;
         cfg_ff.rate_increment  <= RST_RATE_INC;
         cfg_ff.iteration_total <= RST_ITER_TOTAL;
         cfg_ff.keep_count      <= RST_KEEP_COUNT;
         cfg_ff.x_start         <= RST_X_START;
         cfg_ff.image_height    <= RST_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/lmbp_ctrl.sv
// ---------------------------------------------------------------------------
// lmbp_ctrl
// Sequencer that steps one item through the shared multiplier.
// ---------------------------------------------------------------------------
module lmbp_ctrl
   import lmbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_start_req,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RATE = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;
   localparam logic [2:0] S_ROW  = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.take_item   = take;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_start_req) begin
                  state_in = S_RATE;
               end else if (!status.exhausted) begin
                  state_in = S_MUL1;
               end
            end
         end
         S_RATE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RATE;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_column = 1'b1;
            state_in        = status.total_zero ? S_IDLE : S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_XX;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GROW;
            state_in    = S_UPD;
         end
         S_UPD: begin
            cmd.update_x = 1'b1;
            state_in     = status.keep_point ? S_ROW : S_IDLE;
         end
         S_ROW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/lmbp_datapath.sv
// ---------------------------------------------------------------------------
// lmbp_datapath
// Map state, shared 32 by 32 multiplier and the result register.
// ---------------------------------------------------------------------------
module lmbp_datapath
   import lmbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [COL_W-1:0] req_column,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [COL_W-1:0] rsp_point_column,
   output logic [ROW_W-1:0] rsp_point_row,
   output logic [X_W-1:0]   rsp_x_value,
   output logic             rsp_last
);

   logic [COL_W-1:0]  req_col_ff;
   logic [X_W-1:0]    population_ff, population_in;
   logic [RATE_W-1:0] growth_rate_ff, growth_rate_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [PROD_W-1:0] prod_ff;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [X_W-1:0]    out_x_ff;
   logic              out_last_ff;

   logic [31:0]       mul_a, mul_b;
   logic [RATE_W+15-1:0] rate_sum;
   logic [RATE_W-1:0] rate_sat;
   logic [X_W+2:0]    x_wide;
   logic [X_W-1:0]    x_sat;
   logic [CNT_W-1:0]  first_kept;
   logic [HEIGHT_W-1:0] height_eff;
   logic [ROW_W-1:0]  height_m1;
   logic [31:0]       row_raw;
   logic [ROW_W-1:0]  row_val;

   // Usable height: zero counts as one, and the image is at most MAX_HEIGHT rows.
   always_comb begin
      if (cfg.image_height == '0) begin
         height_eff = HEIGHT_W'(1);
      end else if (cfg.image_height > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end else begin
         height_eff = cfg.image_height;
      end
   end
   assign height_m1 = ROW_W'(height_eff - HEIGHT_W'(1));

   // Operand selection. The negation gives 1 - x; for x of zero the product is
   // zero either way, which matches the exact result.
   always_comb begin
      case (cmd.mul_sel)
         MUL_RATE: begin
            mul_a = 32'(req_col_ff);
            mul_b = cfg.rate_increment;
         end
         MUL_XX: begin
            mul_a = population_ff;
            mul_b = -population_ff;
         end
         MUL_GROW: begin
            mul_a = growth_rate_ff;
            mul_b = prod_ff[PROD_W-1:X_W];
         end
         default: begin
            mul_a = -population_ff;
            mul_b = 32'(height_m1);
         end
      endcase
   end

   // Growth rate of a new column, saturated at 4.0. The column field is
   // exactly as wide as the column range, so no wrap is needed.
   assign rate_sum = (RATE_W+15)'(cfg.rate_min) + prod_ff[RATE_W+15-1:0];
   assign rate_sat = (rate_sum > (RATE_W+15)'(RATE_FOUR)) ? RATE_FOUR
                                                          : rate_sum[RATE_W-1:0];

   // New population from r * p, held just below 1.0.
   assign x_wide = prod_ff[PROD_W-1:RATE_FRAC];
   assign x_sat  = (x_wide[X_W+2:X_W] != '0) ? '1 : x_wide[X_W-1:0];

   // First iteration that gives a plotted point.
   assign first_kept = (cfg.iteration_total > cfg.keep_count)
                     ? cfg.iteration_total - cfg.keep_count : '0;

   // Plot row; a population of zero means the full height.
   assign row_raw = prod_ff[PROD_W-1:X_W];
   always_comb begin
      if (population_ff == '0) begin
         row_val = height_m1;
      end else if (row_raw > 32'(height_m1)) begin
         row_val = height_m1;
      end else begin
         row_val = row_raw[ROW_W-1:0];
      end
   end

   // Next values of the map state.
   always_comb begin
      population_in  = population_ff;
      growth_rate_in = growth_rate_ff;
      count_in       = count_ff;
      column_in      = column_ff;
      last_in        = last_ff;
      if (cmd.load_column) begin
         growth_rate_in = rate_sat;
         population_in  = cfg.x_start;
         column_in      = req_col_ff;
         count_in       = '0;
      end
      if (cmd.update_x) begin
         population_in = x_sat;
         count_in      = count_ff + CNT_W'(1);
         last_in       = ({1'b0, count_ff} + (CNT_W+1)'(1)) == {1'b0, cfg.iteration_total};
      end
   end

   // The result register is freed by the consumer and refilled by the sequencer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         population_ff  <= '0;
         growth_rate_ff <= '0;
         count_ff       <= '0;
         column_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         population_ff  <= population_in;
         growth_rate_ff <= growth_rate_in;
         count_ff       <= count_in;
         column_ff      <= column_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (cmd.take_item) begin
         req_col_ff <= req_column;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.emit) begin
         out_col_ff  <= column_ff;
         out_row_ff  <= row_val;
         out_x_ff    <= population_ff;
         out_last_ff <= last_ff;
      end
   end

   assign status.exhausted  = (count_ff >= cfg.iteration_total);
   assign status.total_zero = (cfg.iteration_total == '0);
   assign status.keep_point = (count_ff >= first_kept);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_column = out_col_ff;
   assign rsp_point_row    = out_row_ff;
   assign rsp_x_value      = out_x_ff;
   assign rsp_last         = out_last_ff;

endmodule

### rtl/logistic_map_bifurcation_point_gen.sv
// A plain tick steps through MUL1, MUL2, UPD, ROW and EMIT, a start tick first through
// RATE and LOAD; one that keeps no point ends after UPD, and one past the column's end
// does nothing. Ticks are taken only in idle, and EMIT waits for a free result
// register. The single shared multiplier is used in turn by every product of a tick.
// Reset is synchronous and active high: the map state clears to zero and the
// registers take their defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
// logistic_map_bifurcation_point_gen
// Iterates the logistic map per column and emits the plotted points.
// ---------------------------------------------------------------------------
module logistic_map_bifurcation_point_gen
   import lmbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_start_req,
   input  logic [COL_W-1:0]      req_column,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COL_W-1:0]      rsp_point_column,
   output logic [ROW_W-1:0]      rsp_point_row,
   output logic [X_W-1:0]        rsp_x_value,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   lmbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lmbp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   lmbp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_column       (req_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_column (rsp_point_column),
      .rsp_point_row    (rsp_point_row),
      .rsp_x_value      (rsp_x_value),
      .rsp_last         (rsp_last)
   );

endmodule

### rtl/lmbp_checker.sv
// ---------------------------------------------------------------------------
// lmbp_checker
// Port-level checks of the bifurcation point generator, bound to the top.
// ---------------------------------------------------------------------------
`include "logistic_map_bifurcation_point_gen_assert.svh"

module lmbp_checker
   import lmbp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_start_req,
   input logic [COL_W-1:0]      req_column,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COL_W-1:0]      rsp_point_column,
   input logic [ROW_W-1:0]      rsp_point_row,
   input logic [X_W-1:0]        rsp_x_value,
   input logic                  rsp_last,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // A stalled item keeps its payload.
   `LMBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point_column) && $stable(rsp_point_row) && $stable(rsp_x_value) && $stable(rsp_last))

   // A start item always needs the rate multiply, so the input closes.
   `LMBP_ASSERT_NEXT(a_start_busy, clock, reset, req_valid && req_ready && req_start_req, !req_ready)

   // A new item appears only from the end of the sequence, never while idle.
   `LMBP_ASSERT_IMPLIES(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // Leaving reset, no result is pending.
   `LMBP_ASSERT_IMPLIES(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind logistic_map_bifurcation_point_gen lmbp_checker u_checker (.*);

### verif/logistic_map_bifurcation_point_gen_checker.sv
// ---------------------------------------------------------------------------
// Bifurcation point checker
// Watches the tick, point and register ports of the bifurcation point
// generator. It keeps its own copy of the map state and registers, predicts
// each plotted point from every accepted tick, and compares every accepted
// point, field by field, with the oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module logistic_map_bifurcation_point_gen_checker
   import lmbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_start_req,
   input  logic [COL_W-1:0]      req_column,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [COL_W-1:0]      rsp_point_column,
   input  logic [ROW_W-1:0]      rsp_point_row,
   input  logic [X_W-1:0]        rsp_x_value,
   input  logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    points_waiting,
   output int                    points_checked,
   output int                    ticks_taken
);

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [X_W-1:0]   x_value;
      logic             last;
   } plot_point_t;

   // One in Q0.32, held at product width.
   localparam logic [PROD_W-1:0] X_UNIT = 64'h1_0000_0000;

   cfg_type           csr_shadow;
   logic [X_W-1:0]    map_x;
   logic [RATE_W-1:0] map_rate;
   logic [CNT_W-1:0]  tick_index;
   logic [COL_W-1:0]  plot_column;
   plot_point_t       expected_points[$];

   // One mismatch: a single line, and always counted.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("mismatch after %0d points: %s got 0x%0h, expected 0x%0h",
               points_checked, what, got, want);
   endtask

   // Advances the map by one tick and says whether the tick plots a point.
   function automatic bit step_logistic_map(input logic start,
                                            input logic [COL_W-1:0] col,
                                            output plot_point_t pt);
      logic [PROD_W-1:0] rate, wide_col, wide_inc, x_old, x_new, scale, row;
      logic [CNT_W-1:0]  done, first_kept;
      pt = '0;
      // A start tick reloads the column before iterating in the same tick.
      if (start) begin
         rate     = csr_shadow.rate_min;
         wide_col = col;
         wide_inc = csr_shadow.rate_increment;
         rate     = rate + wide_col * wide_inc;
         map_rate    = (rate > RATE_FOUR) ? RATE_FOUR : rate[RATE_W-1:0];
         map_x       = csr_shadow.x_start;
         plot_column = col;
         tick_index  = '0;
      end
      // A finished column ignores further ticks.
      if (tick_index >= csr_shadow.iteration_total) begin
         return 1'b0;
      end
      // x * (1 - x) in Q0.32, then times the rate, saturated below one.
      x_old = map_x;
      x_new = (x_old * (X_UNIT - x_old)) >> X_W;
      rate  = map_rate;
      x_new = (rate * x_new) >> RATE_FRAC;
      if (x_new >= X_UNIT) begin
         x_new = X_UNIT - 1;
      end
      map_x = x_new[X_W-1:0];
      done       = tick_index;
      tick_index = tick_index + 1'b1;
      // Only the final iterations of a column are plotted.
      first_kept = (csr_shadow.iteration_total > csr_shadow.keep_count) ?
                   csr_shadow.iteration_total - csr_shadow.keep_count : '0;
      if (done < first_kept) begin
         return 1'b0;
      end
      // Row scaling with the height limited to the usable range.
      scale = csr_shadow.image_height;
      if (scale == 0) begin
         scale = 1;
      end else if (scale > MAX_HEIGHT) begin
         scale = MAX_HEIGHT;
      end
      row = ((X_UNIT - x_new) * (scale - 1)) >> X_W;
      if (row > scale - 1) begin
         row = scale - 1;
      end
      pt.column  = plot_column;
      pt.row     = row[ROW_W-1:0];
      pt.x_value = map_x;
      pt.last    = (done + 1'b1 == csr_shadow.iteration_total);
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch_ports
      plot_point_t want;
      plot_point_t fresh;
      if (reset) begin
         csr_shadow.rate_min        = RST_RATE_MIN;
         csr_shadow.rate_increment  = RST_RATE_INC;
         csr_shadow.iteration_total = RST_ITER_TOTAL;
         csr_shadow.keep_count      = RST_KEEP_COUNT;
         csr_shadow.x_start         = RST_X_START;
         csr_shadow.image_height    = RST_HEIGHT;
         map_x       = '0;
         map_rate    = '0;
         tick_index  = '0;
         plot_column = '0;
         expected_points.delete();
         fail_count     = 0;
         points_checked = 0;
         ticks_taken    = 0;
      end else begin
         // Register writes; unused indexes are ignored.
         if (csr_wr_en) begin
            case (csr_index)
               REG_RATE_MIN:   csr_shadow.rate_min        = csr_wdata[RATE_W-1:0];
               REG_RATE_INC:   csr_shadow.rate_increment  = csr_wdata[RATE_W-1:0];
               REG_ITER_TOTAL: csr_shadow.iteration_total = csr_wdata[CNT_W-1:0];
               REG_KEEP_COUNT: csr_shadow.keep_count      = csr_wdata[CNT_W-1:0];
               REG_X_START:    csr_shadow.x_start         = csr_wdata[X_W-1:0];
               REG_HEIGHT:     csr_shadow.image_height    = csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         // A point leaving now can only belong to an earlier tick.
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("point with none expected, column", rsp_point_column, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_column !== want.column) begin
                  report_mismatch("point_column", rsp_point_column, want.column);
               end
               if (rsp_point_row !== want.row) begin
                  report_mismatch("point_row", rsp_point_row, want.row);
               end
               if (rsp_x_value !== want.x_value) begin
                  report_mismatch("x_value", rsp_x_value, want.x_value);
               end
               if (rsp_last !== want.last) begin
                  report_mismatch("last", rsp_last, want.last);
               end
            end
            points_checked++;
         end
         // Each accepted tick may plot one point.
         if (req_valid && req_ready) begin
            ticks_taken++;
            if (step_logistic_map(req_start_req, req_column, fresh)) begin
               expected_points.push_back(fresh);
            end
         end
      end
      points_waiting = expected_points.size();
   end

endmodule

### verif/logistic_map_bifurcation_point_gen_tb.sv
// ---------------------------------------------------------------------------
// Bifurcation point generator testbench
// Drives columns of logistic map ticks into the generator under several
// register settings and handshake idling patterns, including a long output
// hold-off and a drain pause, while a checker predicts and compares points.
// ---------------------------------------------------------------------------
module logistic_map_bifurcation_point_gen_tb;
   import lmbp_pkg::*;

   // Slowest run: about 900 ticks, plus sender gaps, receiver stalls, drains
   // and the hold-off; the limit is many times that.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int TICK_BUDGET  = 880;
   localparam int COLUMN_CAP   = 60;

   // Indexes beyond the register list, written to show they are ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_start_req = 1'b0;
   logic [COL_W-1:0]      req_column    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [COL_W-1:0]      rsp_point_column;
   logic [ROW_W-1:0]      rsp_point_row;
   logic [X_W-1:0]        rsp_x_value;
   logic                  rsp_last;
   logic                  csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   int      fail_count;
   int      points_waiting;
   int      points_checked;
   int      ticks_taken;
   int      sender_idle_pct    = 0;
   int      receiver_stall_pct = 0;
   int      cycle_count        = 0;
   int      settings_applied   = 0;
   int      hold_left          = 0;
   bit      hold_token         = 1'b0;
   bit      hold_seen          = 1'b0;
   cfg_type active_cfg;

   logistic_map_bifurcation_point_gen u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_req    (req_start_req),
      .req_column       (req_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_column (rsp_point_column),
      .rsp_point_row    (rsp_point_row),
      .rsp_x_value      (rsp_x_value),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   logistic_map_bifurcation_point_gen_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_req    (req_start_req),
      .req_column       (req_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_column (rsp_point_column),
      .rsp_point_row    (rsp_point_row),
      .rsp_x_value      (rsp_x_value),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .points_waiting   (points_waiting),
      .points_checked   (points_checked),
      .ticks_taken      (ticks_taken)
   );

   // Clock with a period of 8.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d points outstanding.",
                  cycle_count, points_waiting);
         $display("logistic_map_bifurcation_point_gen test failed");
         $finish;
      end
   end

   // Point receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Offers one tick, with random idle cycles first, and waits until taken.
   task automatic send_tick(input logic start, input logic [COL_W-1:0] col);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_column    <= col;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted point has arrived and
   // any tick that plots nothing has had time to finish.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (points_waiting != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes every register; narrow registers may carry junk upper bits.
   task automatic apply_settings(input cfg_type c, input bit junk, input bit spare);
      logic [CSR_DATA_W-1:0] pad;
      pad = junk ? $urandom : '0;
      write_reg(REG_RATE_MIN, c.rate_min);
      write_reg(REG_RATE_INC, c.rate_increment);
      write_reg(REG_ITER_TOTAL, {pad[CSR_DATA_W-1:CNT_W], c.iteration_total});
      write_reg(REG_KEEP_COUNT, {pad[CSR_DATA_W-1:CNT_W], c.keep_count});
      write_reg(REG_X_START, c.x_start);
      write_reg(REG_HEIGHT, {pad[CSR_DATA_W-1:HEIGHT_W], c.image_height});
      if (spare) begin
         write_reg(REG_SPARE_A, $urandom);
         write_reg(REG_SPARE_B, $urandom);
      end
      csr_wr_en  <= 1'b0;
      active_cfg  = c;
      settings_applied++;
   endtask

   // Register setting for one random stretch: one at the top of every
   // range, one at the bottom, the rest random with the extremes mixed in.
   function automatic cfg_type pick_settings(input int kind);
      cfg_type c;
      if (kind == 1) begin
         c.rate_min        = RATE_FOUR;
         c.rate_increment  = RATE_FOUR;
         c.iteration_total = 12'd4095;
         c.keep_count      = 12'd4095;
         c.x_start         = 32'hFFFF_FFFF;
         c.image_height    = MAX_HEIGHT;
      end else if (kind == 2) begin
         c.rate_min        = '0;
         c.rate_increment  = '0;
         c.iteration_total = 12'd1;
         c.keep_count      = '0;
         c.x_start         = '0;
         c.image_height    = 13'd1;
      end else begin
         case ($urandom_range(7))
            0:       c.rate_min = '0;
            1:       c.rate_min = RATE_FOUR;
            2, 3:    c.rate_min = $urandom_range(32'h8000_0000);
            default: c.rate_min = $urandom_range(32'h8000_0000, 32'h5000_0000);
         endcase
         case ($urandom_range(7))
            0:       c.rate_increment = '0;
            1:       c.rate_increment = RATE_FOUR;
            default: c.rate_increment = $urandom_range(32'h0004_0000);
         endcase
         c.iteration_total = ($urandom_range(7) == 0) ? 12'd1
                                                     : CNT_W'($urandom_range(40, 2));
         case ($urandom_range(7))
            0:       c.keep_count = '0;
            1:       c.keep_count = 12'd4095;
            default: c.keep_count = CNT_W'($urandom_range(c.iteration_total + 4));
         endcase
         case ($urandom_range(7))
            0:       c.x_start = '0;
            1:       c.x_start = 32'hFFFF_FFFF;
            default: c.x_start = $urandom;
         endcase
         case ($urandom_range(9))
            0:       c.image_height = '0;
            1:       c.image_height = 13'h1FFF;
            2:       c.image_height = 13'd1;
            3:       c.image_height = MAX_HEIGHT;
            default: c.image_height = HEIGHT_W'($urandom_range(4096, 2));
         endcase
      end
      return c;
   endfunction

   // Mostly whole columns (a start tick, then plain ticks to the end, at most COLUMN_CAP
   // ticks in all, and up to two more), with stray start and plain ticks mixed in.
   task automatic run_columns(input int budget, input bit squeeze, input bit pause);
      int               sent;
      int               len;
      int               k;
      bit               squeezed;
      bit               paused;
      logic [COL_W-1:0] col;
      sent     = 0;
      squeezed = 1'b0;
      paused   = 1'b0;
      while (sent < budget) begin
         col = COL_W'($urandom_range(16383));
         if ($urandom_range(99) < 85) begin
            len = active_cfg.iteration_total;
            if (len > COLUMN_CAP) begin
               len = COLUMN_CAP;
            end
            send_tick(1'b1, col);
            for (k = 1; k < len; k++) begin
               col = COL_W'($urandom_range(16383));
               send_tick(1'b0, col);
            end
            sent += len;
            // Extra ticks; past the end of the column they plot nothing.
            repeat ($urandom_range(2)) begin
               col = COL_W'($urandom_range(16383));
               send_tick(1'b0, col);
               sent++;
            end
         end else begin
            send_tick(1'($urandom_range(1)), col);
            sent++;
         end
         if (squeeze && !squeezed && sent >= budget / 4) begin
            hold_token <= ~hold_token;
            squeezed    = 1'b1;
         end
         if (pause && !paused && sent >= budget / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin : stimulus
      cfg_type c;
      int      phase;
      int      k;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ticks before any start, with the rate at its ceiling, x at one half
      // so the product reaches one, more kept points than iterations and a
      // zero height; then a finished column and an overflowing rate.
      c.rate_min        = RATE_FOUR;
      c.rate_increment  = 32'hFFFF_FFFF;
      c.iteration_total = 12'd3;
      c.keep_count      = 12'd4095;
      c.x_start         = 32'h8000_0000;
      c.image_height    = '0;
      apply_settings(c, 1'b0, 1'b1);
      send_tick(1'b0, 14'h3FFF);
      send_tick(1'b0, 14'h0000);
      send_tick(1'b1, 14'h0000);
      send_tick(1'b0, 14'h2AAA);
      send_tick(1'b0, 14'h1555);
      send_tick(1'b0, 14'h3FFF);
      send_tick(1'b1, 14'h3FFF);
      send_tick(1'b0, 14'h0000);
      wait_drained();

      // A zero iteration total never plots anything.
      c.rate_min        = '0;
      c.rate_increment  = '0;
      c.iteration_total = '0;
      c.keep_count      = '0;
      c.x_start         = '0;
      c.image_height    = MAX_HEIGHT;
      apply_settings(c, 1'b0, 1'b0);
      send_tick(1'b1, 14'h2AAA);
      send_tick(1'b0, 14'h1555);
      wait_drained();

      // Only the last tick kept, the smallest x and a height over the limit.
      c.rate_min        = 32'h6000_0000;
      c.rate_increment  = 32'd1;
      c.iteration_total = 12'd2;
      c.keep_count      = 12'd1;
      c.x_start         = 32'd1;
      c.image_height    = 13'h1FFF;
      apply_settings(c, 1'b0, 1'b0);
      send_tick(1'b1, 14'd100);
      send_tick(1'b0, 14'd0);
      send_tick(1'b0, 14'd0);
      send_tick(1'b1, 14'd8191);
      send_tick(1'b0, 14'd0);
      wait_drained();

      // Random columns under each idling pattern, two settings apiece.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct     = 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct     = 53;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct     = 0;
               receiver_stall_pct <= 53;
            end
            default: begin
               sender_idle_pct     = 29;
               receiver_stall_pct <= 29;
            end
         endcase
         for (k = 0; k < 2; k++) begin
            apply_settings(pick_settings(phase * 2 + k), 1'b1, 1'b0);
            run_columns(TICK_BUDGET / 8, phase == 0 && k == 1, phase == 1 && k == 0);
            wait_drained();
         end
      end

      $display("Ran %0d register settings under four idling patterns, with a long",
               settings_applied);
      $display("output hold-off and a drain pause: %0d ticks, %0d points checked.",
               ticks_taken, points_checked);
      if (fail_count == 0 && points_waiting == 0) begin
         $display("logistic_map_bifurcation_point_gen test passed");
      end else begin
         $display("logistic_map_bifurcation_point_gen test failed");
      end
      $finish;
   end

endmodule
